>>> rtl/crp_pkg.sv
package crp_pkg;

    // Array depth and fixed-point format
    localparam int MAX_POINTS    = 64;
    localparam int FRACTION_BITS = 16;
    localparam int MIN_POINTS    = 2;
    localparam int TAPS          = 4;

    // Field widths
    localparam int COORD_W = 32;
    localparam int TIME_W  = 24;
    localparam int CNT_W   = $clog2(MAX_POINTS + 1);
    localparam int ADDR_W  = $clog2(MAX_POINTS);
    localparam int STAT_W  = 2;

    // Internal widths
    localparam int U_W     = FRACTION_BITS + 1;                 // |u| < 1.0
    localparam int W_W     = FRACTION_BITS + 5;                 // blend weights
    localparam int IDX_W   = TIME_W - FRACTION_BITS + CNT_W + 2;
    localparam int MUL_B_W = (W_W > CNT_W + 1) ? W_W : CNT_W + 1;
    localparam int P_W     = COORD_W + MUL_B_W;
    localparam int ACC_W   = P_W + 2;
    localparam int TWO_ONE = 1 << (FRACTION_BITS + 1);

    // Stream packing
    localparam int S_DATA_W = ((3 * COORD_W + TIME_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((3 * COORD_W + CNT_W + 7) / 8) * 8;

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_EVAL   = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK   = 2'd0,
        STAT_FULL = 2'd1,
        STAT_FEW  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        COORD_X = 2'd0,
        COORD_Y = 2'd1,
        COORD_Z = 2'd2
    } coord_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } pt_t;

    typedef struct packed {
        logic   acc_clr;
        logic   acc_en;
        coord_t acc_sel;
    } mac_ctrl_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCALE,
        S_SPLIT,
        S_SQR,
        S_U2,
        S_U3,
        S_MUL,
        S_DRAIN,
        S_LOAD
    } state_t;

endpackage

>>> rtl/crp_store.sv
module crp_store (
    input  logic                       aclk,
    input  logic                       we,
    input  logic [crp_pkg::ADDR_W-1:0] waddr,
    input  crp_pkg::pt_t               wdata,
    input  logic                       re,
    input  logic [crp_pkg::ADDR_W-1:0] raddr,
    output crp_pkg::pt_t               rdata
);
    import crp_pkg::*;

    pt_t mem [MAX_POINTS];
    pt_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/crp_mac.sv
module crp_mac (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic signed [crp_pkg::COORD_W-1:0] op_a,
    input  logic signed [crp_pkg::MUL_B_W-1:0] op_b,
    input  crp_pkg::mac_ctrl_t                 ctrl,
    output logic signed [crp_pkg::P_W-1:0]     prod,
    output logic signed [crp_pkg::ACC_W-1:0]   acc_x,
    output logic signed [crp_pkg::ACC_W-1:0]   acc_y,
    output logic signed [crp_pkg::ACC_W-1:0]   acc_z
);
    import crp_pkg::*;

    logic signed [P_W-1:0]   prod_reg;
    logic                    acc_en_reg;
    coord_t                  acc_sel_reg;
    logic signed [ACC_W-1:0] acc_x_reg;
    logic signed [ACC_W-1:0] acc_y_reg;
    logic signed [ACC_W-1:0] acc_z_reg;
    logic signed [ACC_W-1:0] prod_ext;

    always_ff @(posedge aclk) begin
        prod_reg    <= P_W'(op_a) * P_W'(op_b);
        acc_sel_reg <= ctrl.acc_sel;
    end

    // accumulate lags the multiply by the product register; acc_en is registered with it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_en_reg <= 1'b0;
        end else begin
            acc_en_reg <= ctrl.acc_en;
        end
    end

    assign prod_ext = ACC_W'(prod_reg);

    always_ff @(posedge aclk) begin
        if (ctrl.acc_clr) begin
            acc_x_reg <= '0;
            acc_y_reg <= '0;
            acc_z_reg <= '0;
        end else if (acc_en_reg) begin
            unique case (acc_sel_reg)
                COORD_X: acc_x_reg <= acc_x_reg + prod_ext;
                COORD_Y: acc_y_reg <= acc_y_reg + prod_ext;
                COORD_Z: acc_z_reg <= acc_z_reg + prod_ext;
                default: acc_x_reg <= acc_x_reg;
            endcase
        end
    end

    assign prod  = prod_reg;
    assign acc_x = acc_x_reg;
    assign acc_y = acc_y_reg;
    assign acc_z = acc_z_reg;

endmodule

>>> rtl/catmull_rom_path_evaluator.sv
// Catmull-Rom path evaluator.
// s_ channel: one beat per command. tuser[0] picks append (0) or evaluate (1).
// Append writes the point at the end of the 64-entry waypoint RAM and returns
// one result beat at once (zero coordinates, new count, status). Evaluate
// scales the time by (count-1), splits it into segment index and local u,
// forms u^2 and u^3, the four blend weights, then reads the four neighbour
// points and runs twelve multiply-accumulates through one shared multiplier.
// Evaluate steps from the accepted beat to the result beat: five setup
// multiplies/steps, twelve MAC steps (one RAM read per point, three
// products per read), then a drain step and a saturating load. Append and the
// too-few-points case answer in the cycle after acceptance.
// Throughput: appends and too-few evaluates one beat per cycle while the
// output is taken; a full evaluate takes no new beat until its result leaves.
// cfg_we/cfg_wdata set the looping bit (wrap neighbours on a closed path);
// write it only while idle.
// One command at a time: s_tready is high only in idle with the output slot
// free or draining. A stalled receiver holds the result beat in m_ and the
// block waits with it. aresetn (sync, active low) empties the path and clears
// looping; RAM contents are not cleared.
module catmull_rom_path_evaluator (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic                         cfg_wdata,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // point_x, point_y, point_z, time_req
    input  logic [crp_pkg::S_DATA_W-1:0] s_tdata,
    // operation
    input  logic [0:0]                   s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // out_x, out_y, out_z, point_count, zero pad
    output logic [crp_pkg::M_DATA_W-1:0] m_tdata,
    // status
    output logic [crp_pkg::STAT_W-1:0]   m_tuser
);
    import crp_pkg::*;

    state_t                    state_reg, state_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic                      looping_reg;
    logic signed [TIME_W-1:0]  time_reg, time_next;
    logic signed [IDX_W-1:0]   idx_reg, idx_next;
    logic signed [U_W-1:0]     u_reg, u_next;
    logic signed [W_W-1:0]     w_reg [TAPS];
    logic signed [W_W-1:0]     w_next [TAPS];
    logic [1:0]                j_reg, j_next;
    coord_t                    k_reg, k_next;

    logic                      m_valid_reg, m_valid_next;
    logic signed [COORD_W-1:0] ox_reg, ox_next;
    logic signed [COORD_W-1:0] oy_reg, oy_next;
    logic signed [COORD_W-1:0] oz_reg, oz_next;
    logic [CNT_W-1:0]          ocnt_reg, ocnt_next;
    status_t                   ostat_reg, ostat_next;

    logic                      out_free;
    logic                      full;
    logic signed [COORD_W-1:0] op_a;
    logic signed [MUL_B_W-1:0] op_b;
    mac_ctrl_t                 mac_ctrl;
    logic signed [P_W-1:0]     prod;
    logic signed [ACC_W-1:0]   acc_x, acc_y, acc_z;

    logic                      st_we, st_re;
    pt_t                       st_wdata, st_rdata;
    logic [ADDR_W-1:0]         st_raddr;

    logic [1:0]                pick_j;
    logic signed [IDX_W:0]     cand, cand_w, mx;

    logic                      sc_neg;
    logic [P_W-1:0]            sc_mag;
    logic signed [IDX_W-1:0]   idx_mag;
    logic signed [U_W-1:0]     u_mag;
    logic signed [U_W-1:0]     upow;
    logic signed [W_W-1:0]     uw, u2w, u3w;

    function automatic logic signed [COORD_W-1:0] sat_out(
        input logic signed [ACC_W-1:0] acc
    );
        logic signed [ACC_W-1:0] sh;
        sh = acc >>> (FRACTION_BITS + 1);
        if (&sh[ACC_W-1:COORD_W-1] || ~|sh[ACC_W-1:COORD_W-1]) begin
            sat_out = sh[COORD_W-1:0];
        end else if (sh[ACC_W-1]) begin
            sat_out = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            sat_out = {1'b0, {(COORD_W-1){1'b1}}};
        end
    endfunction

    crp_store u_store (
        .aclk  (aclk),
        .we    (st_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (st_wdata),
        .re    (st_re),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    crp_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .op_a    (op_a),
        .op_b    (op_b),
        .ctrl    (mac_ctrl),
        .prod    (prod),
        .acc_x   (acc_x),
        .acc_y   (acc_y),
        .acc_z   (acc_z)
    );

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign full     = (count_reg == CNT_W'(MAX_POINTS));

    // x in the low bits, then y, then z
    assign st_wdata = s_tdata[3*COORD_W-1:0];

    // Neighbour index: idx-1+j, wrapped once when looping, then clamped
    assign mx     = (IDX_W+1)'(count_reg) - (IDX_W+1)'(1);
    assign cand   = (IDX_W+1)'(idx_reg) + (IDX_W+1)'(pick_j) - (IDX_W+1)'(1);
    always_comb begin
        cand_w = cand;
        if (looping_reg) begin
            if (cand < 0) begin
                cand_w = mx + cand;
            end else if (cand > mx) begin
                cand_w = cand - mx;
            end
        end
        if (cand_w < 0) begin
            st_raddr = '0;
        end else if (cand_w > mx) begin
            st_raddr = mx[ADDR_W-1:0];
        end else begin
            st_raddr = cand_w[ADDR_W-1:0];
        end
    end

    // Split of scaled time: index truncates toward zero, u keeps the sign
    assign sc_neg  = prod[P_W-1];
    assign sc_mag  = sc_neg ? P_W'(-prod) : P_W'(prod);
    assign idx_mag = sc_mag[FRACTION_BITS +: IDX_W];
    assign u_mag   = {1'b0, sc_mag[FRACTION_BITS-1:0]};
    // floor(prod / ONE), used for u^2 and u^3
    assign upow    = prod[FRACTION_BITS +: U_W];

    assign uw  = W_W'(u_reg);
    assign u3w = W_W'(upow);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            looping_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                looping_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        time_reg  <= time_next;
        idx_reg   <= idx_next;
        u_reg     <= u_next;
        w_reg     <= w_next;
        j_reg     <= j_next;
        k_reg     <= k_next;
        ox_reg    <= ox_next;
        oy_reg    <= oy_next;
        oz_reg    <= oz_next;
        ocnt_reg  <= ocnt_next;
        ostat_reg <= ostat_next;
    end

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        time_next    = time_reg;
        idx_next     = idx_reg;
        u_next       = u_reg;
        w_next       = w_reg;
        j_next       = j_reg;
        k_next       = k_reg;
        m_valid_next = m_valid_reg && !m_tready;
        ox_next      = ox_reg;
        oy_next      = oy_reg;
        oz_next      = oz_reg;
        ocnt_next    = ocnt_reg;
        ostat_next   = ostat_reg;
        op_a         = '0;
        op_b         = '0;
        mac_ctrl     = '0;
        st_we        = 1'b0;
        st_re        = 1'b0;
        pick_j       = j_reg + 2'd1;
        u2w          = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    if (s_tuser[0] == OP_APPEND) begin
                        m_valid_next = 1'b1;
                        ox_next      = '0;
                        oy_next      = '0;
                        oz_next      = '0;
                        if (full) begin
                            ocnt_next  = count_reg;
                            ostat_next = STAT_FULL;
                        end else begin
                            st_we      = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                            ocnt_next  = count_next;
                            ostat_next = STAT_OK;
                        end
                    end else if (count_reg < CNT_W'(MIN_POINTS)) begin
                        m_valid_next = 1'b1;
                        ox_next      = '0;
                        oy_next      = '0;
                        oz_next      = '0;
                        ocnt_next    = count_reg;
                        ostat_next   = STAT_FEW;
                    end else begin
                        time_next  = s_tdata[3*COORD_W +: TIME_W];
                        state_next = S_SCALE;
                    end
                end
            end
            S_SCALE: begin
                op_a       = COORD_W'(time_reg);
                op_b       = MUL_B_W'(count_reg - CNT_W'(1));
                state_next = S_SPLIT;
            end
            S_SPLIT: begin
                idx_next   = sc_neg ? -idx_mag : idx_mag;
                u_next     = sc_neg ? -u_mag : u_mag;
                state_next = S_SQR;
            end
            S_SQR: begin
                op_a       = COORD_W'(u_reg);
                op_b       = MUL_B_W'(u_reg);
                state_next = S_U2;
            end
            S_U2: begin
                // prod = u*u here; next product is u2*u
                u_next     = u_reg;
                op_a       = COORD_W'(upow);
                op_b       = MUL_B_W'(u_reg);
                w_next[0]  = W_W'(upow);
                state_next = S_U3;
            end
            S_U3: begin
                // w_reg[0] parks u2 for this beat
                u2w          = w_reg[0];
                w_next[0]    = W_W'(-u3w + 2 * u2w - uw);
                w_next[1]    = W_W'(3 * u3w - 5 * u2w + W_W'(TWO_ONE));
                w_next[2]    = W_W'(-3 * u3w + 4 * u2w + uw);
                w_next[3]    = W_W'(u3w - u2w);
                mac_ctrl.acc_clr = 1'b1;
                pick_j       = 2'd0;
                st_re        = 1'b1;
                j_next       = 2'd0;
                k_next       = COORD_X;
                state_next   = S_MUL;
            end
            S_MUL: begin
                unique case (k_reg)
                    COORD_X: op_a = st_rdata.x;
                    COORD_Y: op_a = st_rdata.y;
                    COORD_Z: op_a = st_rdata.z;
                    default: op_a = '0;
                endcase
                op_b             = MUL_B_W'(w_reg[j_reg]);
                mac_ctrl.acc_en  = 1'b1;
                mac_ctrl.acc_sel = k_reg;
                unique case (k_reg)
                    COORD_X: k_next = COORD_Y;
                    COORD_Y: k_next = COORD_Z;
                    default: begin
                        // last coordinate of this point: fetch the next one
                        k_next = COORD_X;
                        if (j_reg == 2'(TAPS - 1)) begin
                            state_next = S_DRAIN;
                        end else begin
                            st_re  = 1'b1;
                            j_next = j_reg + 2'd1;
                        end
                    end
                endcase
            end
            S_DRAIN: begin
                state_next = S_LOAD;
            end
            S_LOAD: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    ox_next      = sat_out(acc_x);
                    oy_next      = sat_out(acc_y);
                    oz_next      = sat_out(acc_z);
                    ocnt_next    = count_reg;
                    ostat_next   = STAT_OK;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_DATA_W'({ocnt_reg, oz_reg, oy_reg, ox_reg});
    assign m_tuser  = ostat_reg;

endmodule

>>> sim/tb_catmull_rom_path_evaluator.sv
module tb_catmull_rom_path_evaluator;
    timeunit 1ns;
    timeprecision 1ps;

    import crp_pkg::*;

    localparam longint UNIT        = longint'(1) << FRACTION_BITS;
    localparam int     STALL_LIMIT = 2000;
    localparam int     HOLD_CYCLES = 300;
    localparam int     PHASE_ITEMS = 76;

    typedef struct packed {
        logic                      op;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic signed [TIME_W-1:0]  tm;
    } cmd_t;

    typedef struct packed {
        status_t                   st;
        logic [CNT_W-1:0]          cnt;
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } path_beat_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic                  cfg_wdata = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic [0:0]            s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic [STAT_W-1:0]     m_tuser;

    // predictor state
    logic signed [COORD_W-1:0] wp_mem [MAX_POINTS][3];
    int                        stored_pts = 0;
    logic                      wrap_mode  = 1'b0;

    cmd_t       pending_cmds[$];
    path_beat_t expected_beats[$];
    cmd_t       cur_cmd;
    int         send_gap  = 0;
    int         stall_left = 0;
    int         hold_req  = 0;
    int         hold_seen = 0;
    int         idle_cycles = 0;
    bit         quiet     = 1'b0;
    int         err_cnt   = 0;
    int         n_app = 0, n_full = 0, n_eval = 0, n_few = 0, n_results = 0;

    catmull_rom_path_evaluator u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // mostly short gaps, a few long ones, none in quiet phases
    function automatic int draw_gap();
        int r;
        r = $urandom_range(99);
        if (quiet || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // applies one command to the path state and returns the result beat
    function automatic path_beat_t step_path(input cmd_t c);
        path_beat_t r;
        longint     m, t, scaled, seg, u, u2, u3, acc, k;
        longint     w[4];
        longint     ix[4];
        logic signed [COORD_W-1:0] res[3];
        res = '{0, 0, 0};
        r.st = STAT_OK;
        if (c.op == OP_APPEND) begin
            n_app++;
            if (stored_pts >= MAX_POINTS) begin
                r.st = STAT_FULL;
                n_full++;
            end else begin
                wp_mem[stored_pts][0] = c.x;
                wp_mem[stored_pts][1] = c.y;
                wp_mem[stored_pts][2] = c.z;
                stored_pts++;
            end
        end else begin
            n_eval++;
            if (stored_pts < MIN_POINTS) begin
                r.st = STAT_FEW;
                n_few++;
            end else begin
                m = stored_pts - 1;
                t = c.tm;
                scaled = t * m;
                // segment index truncates toward zero, so u <= 0 for negative time
                seg = (scaled >= 0) ? (scaled >>> FRACTION_BITS)
                                    : -((-scaled) >>> FRACTION_BITS);
                u  = scaled - seg * UNIT;
                u2 = (u * u) >>> FRACTION_BITS;
                u3 = (u2 * u) >>> FRACTION_BITS;
                w[0] = -u3 + 2 * u2 - u;
                w[1] = 3 * u3 - 5 * u2 + 2 * UNIT;
                w[2] = -3 * u3 + 4 * u2 + u;
                w[3] = u3 - u2;
                for (int j = 0; j < 4; j++) begin
                    k = seg - 1 + j;
                    if (wrap_mode) begin
                        if (k < 0) k = m + k;
                        else if (k > m) k = k - m;
                    end
                    if (k < 0) k = 0;
                    if (k > m) k = m;
                    ix[j] = k;
                end
                for (int a = 0; a < 3; a++) begin
                    acc = 0;
                    for (int j = 0; j < 4; j++)
                        acc += longint'(wp_mem[ix[j]][a]) * w[j];
                    acc = acc >>> (FRACTION_BITS + 1);
                    if (acc > 64'sd2147483647) acc = 64'sd2147483647;
                    else if (acc < -64'sd2147483648) acc = -64'sd2147483648;
                    res[a] = 32'(acc);
                end
            end
        end
        r.x   = res[0];
        r.y   = res[1];
        r.z   = res[2];
        r.cnt = CNT_W'(stored_pts);
        return r;
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        $display("%0t ns: mismatch on %s: got %h, want %h", $time, what, got, want);
        err_cnt++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) report(what, got, want);
    endtask

    // input driver
    always @(posedge aclk) begin
        path_beat_t e;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                e = step_path(cur_cmd);
                expected_beats.insert(expected_beats.size(), e);
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    s_tvalid <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (pending_cmds.size() > 0) begin
                    cur_cmd = pending_cmds.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {cur_cmd.tm, cur_cmd.z, cur_cmd.y, cur_cmd.x};
                    s_tuser  <= cur_cmd.op;
                    send_gap <= draw_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result receiver: random stalls plus one long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else if (hold_seen != hold_req) begin
            hold_seen  <= hold_req;
            stall_left <= HOLD_CYCLES;
            m_tready   <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else begin
            m_tready   <= 1'b1;
            stall_left <= draw_gap();
        end
    end

    // result monitor and watchdog
    always @(posedge aclk) begin
        path_beat_t e;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                n_results++;
                if (expected_beats.size() == 0) begin
                    report("result beat with nothing pending", m_tdata[31:0], 0);
                end else begin
                    e = expected_beats.pop_front();
                    check_field("out_x", m_tdata[31:0], e.x);
                    check_field("out_y", m_tdata[63:32], e.y);
                    check_field("out_z", m_tdata[95:64], e.z);
                    check_field("point_count", 32'(m_tdata[96 +: CNT_W]), 32'(e.cnt));
                    check_field("status", 32'(m_tuser), 32'(e.st));
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
                $display("tb_catmull_rom_path_evaluator: done, errors");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic add_point(input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z);
        cmd_t c;
        c.op = OP_APPEND;
        c.x  = x;
        c.y  = y;
        c.z  = z;
        c.tm = TIME_W'($urandom);
        pending_cmds.insert(pending_cmds.size(), c);
    endtask

    task automatic add_eval(input logic [TIME_W-1:0] tm);
        cmd_t c;
        c.op = OP_EVAL;
        c.x  = $urandom;
        c.y  = $urandom;
        c.z  = $urandom;
        c.tm = tm;
        pending_cmds.insert(pending_cmds.size(), c);
    endtask

    function automatic logic [31:0] corner_val();
        case ($urandom_range(3))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            default: return 32'hffff_ffff;
        endcase
    endfunction

    task automatic add_random();
        int r;
        int v;
        if ($urandom_range(99) < 35) begin
            if ($urandom_range(99) < 20) add_point(corner_val(), corner_val(), corner_val());
            else                          add_point($urandom, $urandom, $urandom);
        end else begin
            r = $urandom_range(99);
            if (r < 60) begin
                add_eval(TIME_W'($urandom_range(0, int'(UNIT))));
            end else if (r < 75) begin
                v = int'($urandom_range(0, 3 * int'(UNIT))) - int'(UNIT);
                add_eval(TIME_W'(v));
            end else begin
                add_eval(TIME_W'($urandom));
            end
        end
    endtask

    // wait until the block has drained and gone idle
    task automatic settle();
        while (pending_cmds.size() > 0 || s_tvalid || expected_beats.size() > 0)
            @(posedge aclk);
        repeat (25) @(posedge aclk);
    endtask

    task automatic write_looping(input logic v);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        wrap_mode = v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_looping(1'b0);

        // empty and single-point store, extreme coordinates, clamped ends
        add_eval(24'h000000);
        add_point(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000);
        add_eval(24'h010000);
        add_point(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
        add_eval(24'h000000);
        add_eval(24'h008000);
        add_eval(24'h7fffff);
        add_eval(24'h800000);
        add_point(32'h0001_0000, 32'hfffe_0000, 32'h1234_5678);
        add_point(32'hffff_ffff, 32'h0000_0001, 32'h7fff_ffff);
        add_eval(24'h010000);
        add_eval(24'hffaaab);  // negative time, u in (-1, 0]
        add_eval(24'h005555);
        add_eval(24'hffffff);
        settle();

        // same store, neighbours wrapped around the closed path
        write_looping(1'b1);
        add_eval(24'h000000);
        add_eval(24'h010000);
        add_eval(24'hff8000);
        add_eval(24'h7fffff);
        add_eval(24'h800000);
        add_eval(24'h00c000);
        settle();

        for (int ph = 0; ph < 5; ph++) begin
            write_looping(ph[0]);
            quiet = (ph == 2);
            for (int i = 0; i < PHASE_ITEMS; i++)
                add_random();
            // stall the result side long enough to back the block up
            if (ph == 1) hold_req = hold_req + 1;
            settle();
        end

        $display("covered %0d appends (%0d dropped on a full store), %0d evaluates",
                 n_app, n_full, n_eval);
        $display("(%0d with too few points), clamped and wrapped ends, %0d results checked",
                 n_few, n_results);
        if (err_cnt == 0) begin
            $display("tb_catmull_rom_path_evaluator: done, clean");
        end else begin
            $display("tb_catmull_rom_path_evaluator: done, errors");
        end
        $finish;
    end

endmodule
